// ===== hdl/bds_pkg.sv =====
package bds_pkg;

   // configuration register map
   localparam int CSR_INDEX_BITS = 1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_FRAME_WIDTH  = 1'b0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_FRAME_HEIGHT = 1'b1;

   localparam int CFG_BITS     = 13;
   localparam int WIDTH_RESET  = 640;
   localparam int HEIGHT_RESET = 480;
   localparam int HEIGHT_LIMIT = 4096;
   localparam int ROW_BITS     = 12;

   // result queue
   localparam int OUT_DEPTH    = 3;
   localparam int OUT_PTR_BITS = 2;
   localparam int OUT_CNT_BITS = 2;

   // raster position of the pixel in transfer
   typedef struct packed {
      logic odd_col;
      logic odd_row;
      logic last_col;
      logic last_row;
   } bds_pos_type;

endpackage

// ===== hdl/bds_line_mem.sv =====
module bds_line_mem #(
   parameter int DEPTH     = 2048,
   parameter int ADDR_BITS = 11,
   parameter int DATA_BITS = 17
) (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [ADDR_BITS-1:0] wr_addr,
   input  logic [DATA_BITS-1:0] wr_data,
   input  logic                 rd_en,
   input  logic [ADDR_BITS-1:0] rd_addr,
   output logic [DATA_BITS-1:0] rd_data
);

   logic [DATA_BITS-1:0] mem [DEPTH];
   logic [DATA_BITS-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hdl/bds_scan.sv =====
module bds_scan #(
   parameter int MAX_WIDTH = 4096,
   parameter int COL_BITS  = 12
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_wen,
   input  logic [bds_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [bds_pkg::CFG_BITS-1:0]       csr_wdata,
   input  logic                               advance,
   output logic [COL_BITS-1:0]                col,
   output bds_pkg::bds_pos_type               pos
);

   import bds_pkg::*;

   logic [COL_BITS-1:0] col_ff, col_in;
   logic [ROW_BITS-1:0] row_ff, row_in;
   logic [COL_BITS-1:0] last_col_ff, last_col_in;
   logic [ROW_BITS-1:0] last_row_ff, last_row_in;

   // zero counts as one, oversize saturates
   function automatic logic [COL_BITS-1:0] col_last_of(input logic [CFG_BITS-1:0] v);
      logic [COL_BITS-1:0] r;
      if (v == '0) begin
         r = '0;
      end else if (int'(v) > MAX_WIDTH) begin
         r = COL_BITS'(MAX_WIDTH - 1);
      end else begin
         r = COL_BITS'(v - 1'b1);
      end
      return r;
   endfunction

   function automatic logic [ROW_BITS-1:0] row_last_of(input logic [CFG_BITS-1:0] v);
      logic [ROW_BITS-1:0] r;
      if (v == '0) begin
         r = '0;
      end else if (int'(v) > HEIGHT_LIMIT) begin
         r = ROW_BITS'(HEIGHT_LIMIT - 1);
      end else begin
         r = ROW_BITS'(v - 1'b1);
      end
      return r;
   endfunction

   always_comb begin
      pos.odd_col  = col_ff[0];
      pos.odd_row  = row_ff[0];
      pos.last_col = (col_ff == last_col_ff);
      pos.last_row = (row_ff == last_row_ff);
   end

   assign col = col_ff;

   always_comb begin
      col_in      = col_ff;
      row_in      = row_ff;
      last_col_in = last_col_ff;
      last_row_in = last_row_ff;
      if (csr_wen) begin
         // any write restarts the frame
         col_in = '0;
         row_in = '0;
         unique case (csr_index)
            CSR_FRAME_WIDTH:  last_col_in = col_last_of(csr_wdata);
            CSR_FRAME_HEIGHT: last_row_in = row_last_of(csr_wdata);
         endcase
      end else if (advance) begin
         if (pos.last_col) begin
            col_in = '0;
            row_in = pos.last_row ? '0 : row_ff + 1'b1;
         end else begin
            col_in = col_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff      <= '0;
         row_ff      <= '0;
         last_col_ff <= col_last_of(CFG_BITS'(WIDTH_RESET));
         last_row_ff <= row_last_of(CFG_BITS'(HEIGHT_RESET));
      end else begin
         col_ff      <= col_in;
         row_ff      <= row_in;
         last_col_ff <= last_col_in;
         last_row_ff <= last_row_in;
      end
   end

endmodule

// ===== hdl/bds_out_fifo.sv =====
module bds_out_fifo #(
   parameter int DATA_BITS = 19
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               push,
   input  logic [DATA_BITS-1:0]               push_data,
   output logic                               pop_valid,
   input  logic                               pop_ready,
   output logic [DATA_BITS-1:0]               pop_data,
   output logic [bds_pkg::OUT_CNT_BITS-1:0]   count
);

   import bds_pkg::*;

   logic [DATA_BITS-1:0]    entry_ff [OUT_DEPTH];
   logic [OUT_PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [OUT_PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [OUT_CNT_BITS-1:0] count_ff, count_in;
   logic                    pop;

   function automatic logic [OUT_PTR_BITS-1:0] ptr_next(input logic [OUT_PTR_BITS-1:0] p);
      return (p == OUT_PTR_BITS'(OUT_DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

   assign pop       = pop_valid && pop_ready;
   assign pop_valid = (count_ff != '0);
   assign pop_data  = entry_ff[rd_ptr_ff];
   assign count     = count_ff;

   always_comb begin
      wr_ptr_in = push ? ptr_next(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop ? ptr_next(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff + OUT_CNT_BITS'(push) - OUT_CNT_BITS'(pop);
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// ===== hdl/box_downsample_2x2.sv =====
// path: a pixel that completes a block is held in the second-stage register, then
//    pushed into the result queue, from which its result can transfer
// throughput: one pixel per cycle while the result queue has room; each pixel makes at most one access to the
//    single-port-per-direction line store (write on even rows but the last, read on odd rows)
// reset: frame position to (0,0), size back to 640 x 480, result queue emptied;
//    the line store is not cleared and needs no clearing pass
module box_downsample_2x2 #(
   parameter int MAX_WIDTH  = 4096,
   parameter int PIXEL_BITS = 16
) (
   input  logic                               clock,
   input  logic                               reset,
   // pixel stream in
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [PIXEL_BITS-1:0]              req_pixel_value,
   // block averages out
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [PIXEL_BITS+1:0]              rsp_average_value,
   output logic                               rsp_frame_done,
   // configuration writes
   input  logic                               csr_wen,
   input  logic [bds_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [bds_pkg::CFG_BITS-1:0]       csr_wdata
);

   import bds_pkg::*;

   localparam int COL_BITS   = (MAX_WIDTH > 2) ? $clog2(MAX_WIDTH) : 1;
   localparam int PAIR_SLOTS = (MAX_WIDTH + 1) / 2;
   localparam int ADDR_BITS  = (PAIR_SLOTS > 1) ? $clog2(PAIR_SLOTS) : 1;
   localparam int SUM_BITS   = PIXEL_BITS + 1;
   localparam int AVG_BITS   = PIXEL_BITS + 2;

   // pixel transfer and raster position
   logic                req_xfer;
   logic [COL_BITS-1:0] col;
   bds_pos_type         pos;

   // column pair being formed
   logic [PIXEL_BITS-1:0] partial_ff, partial_in;
   logic [SUM_BITS-1:0]   pair_sum;
   logic                  pair_done;

   // line store hookup
   logic                 mem_wr_en;
   logic                 mem_rd_en;
   logic [ADDR_BITS-1:0] slot;
   logic [SUM_BITS-1:0]  mem_rd_data;

   // second stage: combine with the row above and scale
   logic                s1_valid_ff, s1_valid_in;
   logic [SUM_BITS-1:0] s1_sum_ff;
   logic                s1_from_mem_ff;
   logic                s1_two_cols_ff;
   logic                s1_done_ff;
   logic [AVG_BITS-1:0] s1_total;
   logic [AVG_BITS-1:0] s1_average;

   // result queue with credit-based admission
   logic [OUT_CNT_BITS-1:0] fifo_count;
   logic [OUT_CNT_BITS:0]   in_flight;
   logic [AVG_BITS:0]       fifo_out;

   assign req_xfer = req_valid && req_ready;

   bds_scan #(
      .MAX_WIDTH (MAX_WIDTH),
      .COL_BITS  (COL_BITS)
   ) u_scan (
      .clock     (clock),
      .reset     (reset),
      .csr_wen   (csr_wen),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .advance   (req_xfer),
      .col       (col),
      .pos       (pos)
   );

   // an even column opens a pair; an odd column or the last column closes it
   assign pair_done = pos.odd_col || pos.last_col;
   assign pair_sum  = pos.odd_col ? ({1'b0, partial_ff} + {1'b0, req_pixel_value})
                                  : {1'b0, req_pixel_value};
   assign partial_in = (req_xfer && !pos.odd_col) ? req_pixel_value : partial_ff;

   always_ff @(posedge clock) begin
      partial_ff <= partial_in;
   end

   // even rows park the pair sum, odd rows fetch it back
   // a last even row has nothing below it and goes straight out
   assign slot      = ADDR_BITS'(col >> 1);
   assign mem_wr_en = req_xfer && pair_done && !pos.odd_row && !pos.last_row;
   assign mem_rd_en = req_xfer && pair_done && pos.odd_row;

   bds_line_mem #(
      .DEPTH     (PAIR_SLOTS),
      .ADDR_BITS (ADDR_BITS),
      .DATA_BITS (SUM_BITS)
   ) u_line_mem (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (slot),
      .wr_data (pair_sum),
      .rd_en   (mem_rd_en),
      .rd_addr (slot),
      .rd_data (mem_rd_data)
   );

   assign s1_valid_in = req_xfer && pair_done && (pos.odd_row || pos.last_row);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         s1_sum_ff      <= pair_sum;
         s1_from_mem_ff <= pos.odd_row;
         s1_two_cols_ff <= pos.odd_col;
         s1_done_ff     <= pos.last_col && pos.last_row;
      end
   end

   // the count is 4, 2 or 1, so times four over count is a left shift
   assign s1_total = (s1_from_mem_ff ? AVG_BITS'(mem_rd_data) : '0) + AVG_BITS'(s1_sum_ff);

   always_comb begin
      unique case ({s1_from_mem_ff, s1_two_cols_ff})
         2'b11:        s1_average = s1_total;
         2'b10, 2'b01: s1_average = s1_total << 1;
         2'b00:        s1_average = s1_total << 2;
      endcase
   end

   bds_out_fifo #(
      .DATA_BITS (AVG_BITS + 1)
   ) u_out_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (s1_valid_ff),
      .push_data ({s1_average, s1_done_ff}),
      .pop_valid (rsp_valid),
      .pop_ready (rsp_ready),
      .pop_data  (fifo_out),
      .count     (fifo_count)
   );

   assign rsp_average_value = fifo_out[AVG_BITS:1];
   assign rsp_frame_done    = fifo_out[0];

   // admit a pixel only while the queue has room for everything in flight
   assign in_flight = {1'b0, fifo_count} + (OUT_CNT_BITS + 1)'(s1_valid_ff);
   assign req_ready = (in_flight < (OUT_CNT_BITS + 1)'(OUT_DEPTH));

   // the line store never sees a read and a write in the same cycle
   a_mem_port_exclusive : assert property (@(posedge clock) disable iff (reset)
      !(mem_wr_en && mem_rd_en))
      else $error("line store read and write in one cycle");

   // a result only comes from a pixel transferred the cycle before
   a_s1_from_transfer : assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff |-> $past(req_valid && req_ready))
      else $error("stage result without a pixel transfer");

   // admission keeps the queue from overflowing
   a_fifo_room : assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff |-> (fifo_count < OUT_CNT_BITS'(OUT_DEPTH)))
      else $error("result pushed into a full queue");

   // a flagged last result leaves the frame position at the origin
   a_frame_wrap : assert property (@(posedge clock) disable iff (reset)
      (s1_valid_in && pos.last_col && pos.last_row) |=> (col == '0 && !pos.odd_row))
      else $error("frame position not wrapped after last pixel");

endmodule

// ===== verif/box_downsample_2x2_tb.sv =====
`timescale 1ns / 1ps
module box_downsample_2x2_tb;
   import bds_pkg::*;

   localparam int PIX_W          = 16;
   localparam int MAX_W          = 4096;
   localparam int PAIR_SLOTS     = MAX_W / 2;
   localparam int DRAIN_CYCLES   = 4;    // covers a pixel on its way through the stage register and the result queue
   localparam int WATCHDOG_LIMIT = 2000; // cycles without any transfer

   // one block average as it leaves the result port
   typedef struct packed {
      logic [PIX_W+1:0] average;
      logic             frame_done;
   } block_avg_type;

   // dut ports, the inputs all driven to known values from time zero
   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_ready;
   logic [PIX_W-1:0]          req_pixel_value = '0;
   logic                      rsp_valid;
   logic                      rsp_ready = 1'b0;
   logic [PIX_W+1:0]          rsp_average_value;
   logic                      rsp_frame_done;
   logic                      csr_wen = 1'b0;
   logic [CSR_INDEX_BITS-1:0] csr_index = CSR_FRAME_WIDTH;
   logic [CFG_BITS-1:0]       csr_wdata = '0;

   // pixel source and idling control
   logic [PIX_W-1:0] pixel_q[$];
   int               pixels_queued = 0;
   int               pixels_taken = 0;
   bit               pix_accepted = 1'b0;
   bit               bursts_on = 1'b1;
   int               send_gap = 0;
   int               hold_gap = 0;
   int               quiet_cycles = 0;
   int               mismatches = 0;

   // frame size as the stimulus side sees it
   int unsigned frame_w = WIDTH_RESET;
   int unsigned frame_h = HEIGHT_RESET;

   // predictor state: its own copy of the line store, position and size registers
   logic [PIX_W:0]    line_pair_sums [0:PAIR_SLOTS-1];
   logic [PIX_W:0]    left_pixel;
   int unsigned       col_pos;
   int unsigned       row_pos;
   logic [CFG_BITS-1:0] width_reg;
   logic [CFG_BITS-1:0] height_reg;
   block_avg_type     pending_averages[$];

   box_downsample_2x2 #(
      .MAX_WIDTH  (MAX_W),
      .PIXEL_BITS (PIX_W)
   ) dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_pixel_value   (req_pixel_value),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_average_value (rsp_average_value),
      .rsp_frame_done    (rsp_frame_done),
      .csr_wen           (csr_wen),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata)
   );

   always #5 clock = ~clock;

   // zero reads as one, anything past the limit saturates
   function automatic int unsigned clamp_size(input logic [CFG_BITS-1:0] v,
                                              input int unsigned limit);
      if (v == 0) return 1;
      if (v > limit) return limit;
      return 32'(v);
   endfunction

   // advance the raster position by one pixel and queue the block average it completes
   function automatic void predict_block_average(input logic [PIX_W-1:0] pix);
      int unsigned     w, h, x, y, slot, ncols, count;
      logic [PIX_W+2:0] pair_sum, total, scaled;
      bit              last_col, last_row, pair_done, emit;
      block_avg_type   res;
      w = clamp_size(width_reg, MAX_W);
      h = clamp_size(height_reg, HEIGHT_LIMIT);
      x = (col_pos >= w) ? 0 : col_pos;
      y = (row_pos >= h) ? 0 : row_pos;
      last_col = (x + 1 == w);
      last_row = (y + 1 == h);
      slot = x / 2;
      pair_sum = '0;
      total = '0;
      ncols = 0;
      count = 0;
      emit = 1'b0;
      // pair the pixel with its left neighbor; an odd last column stands alone
      if (x % 2 == 0) begin
         left_pixel = {1'b0, pix};
         pair_done = last_col;
         if (last_col) begin
            pair_sum = {3'b000, pix};
            ncols = 1;
         end
      end else begin
         pair_sum = {2'b00, left_pixel} + {3'b000, pix};
         ncols = 2;
         pair_done = 1'b1;
      end
      // even rows park the pair in the line store unless it is the last row
      if (pair_done) begin
         if (y % 2 == 0) begin
            if (last_row) begin
               total = pair_sum;
               count = ncols;
               emit = 1'b1;
            end else begin
               line_pair_sums[slot] = pair_sum[PIX_W:0];
            end
         end else begin
            total = {2'b00, line_pair_sums[slot]} + pair_sum;
            count = 2 * ncols;
            emit = 1'b1;
         end
      end
      if (emit) begin
         scaled = (count == 4) ? total : (count == 2) ? (total << 1) : (total << 2);
         res.average = scaled[PIX_W+1:0];
         res.frame_done = last_col && last_row;
         pending_averages.push_back(res);
      end
      if (last_col) begin
         col_pos = 0;
         row_pos = last_row ? 0 : y + 1;
      end else begin
         col_pos = x + 1;
      end
   endfunction

   // monitor: config writes, pixel transfers and result checks, all on the rising edge
   always @(posedge clock) begin : monitor
      block_avg_type want;
      if (reset) begin
         width_reg = CFG_BITS'(WIDTH_RESET);
         height_reg = CFG_BITS'(HEIGHT_RESET);
         col_pos = 0;
         row_pos = 0;
         left_pixel = '0;
         pending_averages.delete();
         pix_accepted <= 1'b0;
      end else begin
         pix_accepted <= req_valid && req_ready;
         // any register write also restarts the frame at pixel (0,0)
         if (csr_wen) begin
            case (csr_index)
               CSR_FRAME_WIDTH: width_reg = csr_wdata;
               CSR_FRAME_HEIGHT: height_reg = csr_wdata;
               default: ;
            endcase
            col_pos = 0;
            row_pos = 0;
            left_pixel = '0;
         end
         if (rsp_valid && rsp_ready) begin
            if (pending_averages.size() == 0) begin
               mismatches++;
               $display("%0t: unexpected result, expected none, actual avg=%0d done=%0b",
                        $time, rsp_average_value, rsp_frame_done);
            end else begin
               want = pending_averages.pop_front();
               if (rsp_average_value !== want.average) begin
                  mismatches++;
                  $display("%0t: average_value expected %0d actual %0d",
                           $time, want.average, rsp_average_value);
               end
               if (rsp_frame_done !== want.frame_done) begin
                  mismatches++;
                  $display("%0t: frame_done expected %0b actual %0b",
                           $time, want.frame_done, rsp_frame_done);
               end
            end
         end
         if (req_valid && req_ready) begin
            predict_block_average(req_pixel_value);
            pixels_taken++;
         end
      end
   end

   // pixel driver: holds valid and payload until the transfer, random gaps in between
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || pix_accepted) begin
         if (send_gap > 0) begin
            send_gap <= send_gap - 1;
            req_valid <= 1'b0;
         end else if (pixel_q.size() != 0) begin
            req_valid <= 1'b1;
            req_pixel_value <= pixel_q.pop_front();
            if (bursts_on && $urandom_range(0, 9) == 0)
               send_gap <= $urandom_range(1, 6);
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // result-side backpressure in bursts of random length
   always @(negedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_gap > 0) begin
         hold_gap <= hold_gap - 1;
         rsp_ready <= 1'b0;
      end else if (bursts_on && $urandom_range(0, 7) == 0) begin
         hold_gap <= $urandom_range(0, 5);
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // watchdog on cycles without any transfer
   always @(posedge clock) begin
      if (reset || csr_wen || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == WATCHDOG_LIMIT) begin
         $display("%0t: no transfer for %0d cycles, %0d results outstanding",
                  $time, quiet_cycles, pending_averages.size());
         $display("[FAIL] regression broken");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic write_csr(input logic [CSR_INDEX_BITS-1:0] idx,
                            input logic [CFG_BITS-1:0] val);
      @(negedge clock);
      csr_wen <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      if (idx == CSR_FRAME_WIDTH)
         frame_w = clamp_size(val, MAX_W);
      else
         frame_h = clamp_size(val, HEIGHT_LIMIT);
      @(negedge clock);
      csr_wen <= 1'b0;
   endtask

   task automatic queue_pixel(input logic [PIX_W-1:0] v);
      pixel_q.push_back(v);
      pixels_queued++;
   endtask

   // wait for every pixel to transfer and every average to arrive,
   // then wait out a pixel still in flight that makes no result
   task automatic drain_block();
      while (pixels_taken != pixels_queued || pending_averages.size() != 0)
         @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   // extremes show up often, the rest is uniform
   function automatic logic [PIX_W-1:0] random_pixel();
      case ($urandom_range(0, 9))
         0: return '0;
         1: return '1;
         default: return PIX_W'($urandom);
      endcase
   endfunction

   // one random frame setting: small sizes, whole frames, sometimes a cut-off frame
   task automatic random_phase(input bit no_idle, output int unsigned sent);
      int unsigned w_raw, h_raw, frame_px, pause_at;
      int          k;
      bursts_on = !no_idle && ($urandom_range(0, 3) != 0);
      w_raw = ($urandom_range(0, 15) == 0) ? 0 :
              ($urandom_range(0, 3) == 0) ? $urandom_range(17, 24) : $urandom_range(1, 16);
      h_raw = ($urandom_range(0, 15) == 0) ? 0 : $urandom_range(1, 8);
      case ($urandom_range(0, 3))
         0: write_csr(CSR_FRAME_WIDTH, CFG_BITS'(w_raw));
         1: write_csr(CSR_FRAME_HEIGHT, CFG_BITS'(h_raw));
         2: begin
            write_csr(CSR_FRAME_WIDTH, CFG_BITS'(w_raw));
            write_csr(CSR_FRAME_HEIGHT, CFG_BITS'(h_raw));
         end
         default: begin
            write_csr(CSR_FRAME_HEIGHT, CFG_BITS'(h_raw));
            write_csr(CSR_FRAME_WIDTH, CFG_BITS'(w_raw));
         end
      endcase
      frame_px = frame_w * frame_h;
      sent = frame_px * ((frame_px <= 64) ? $urandom_range(1, 3) : 1);
      // a cut-off frame is restarted by the next register write
      if ($urandom_range(0, 2) == 0)
         sent += $urandom_range(0, frame_px - 1);
      // sometimes stop mid-phase until every average is back
      pause_at = ($urandom_range(0, 3) == 0) ? $urandom_range(1, sent) : sent + 1;
      for (k = 0; k < sent; k++) begin
         if (k == pause_at)
            drain_block();
         queue_pixel(random_pixel());
      end
      drain_block();
   endtask

   initial begin : stimulus
      int unsigned random_sent, phase_sent;
      int          k;
      repeat (2) @(negedge clock);
      reset <= 1'b0;

      // reset size of 640 wide: one row and the first pair below it, then cut off
      for (k = 0; k < WIDTH_RESET + 2; k++)
         queue_pixel(random_pixel());
      drain_block();

      // full-scale 2x2 block
      write_csr(CSR_FRAME_WIDTH, CFG_BITS'(2));
      write_csr(CSR_FRAME_HEIGHT, CFG_BITS'(2));
      repeat (4) queue_pixel('1);
      drain_block();

      // 3x3: full block, odd last column, odd last row, lone corner, then wrap
      write_csr(CSR_FRAME_WIDTH, CFG_BITS'(3));
      write_csr(CSR_FRAME_HEIGHT, CFG_BITS'(3));
      for (k = 1; k <= 9; k++)
         queue_pixel(PIX_W'(k * 10));
      drain_block();

      // zero size reads as 1x1, every pixel ends a frame
      write_csr(CSR_FRAME_WIDTH, '0);
      write_csr(CSR_FRAME_HEIGHT, '0);
      queue_pixel('1);
      queue_pixel(PIX_W'(1));
      drain_block();

      // a write mid-frame restarts at pixel (0,0)
      write_csr(CSR_FRAME_WIDTH, CFG_BITS'(4));
      write_csr(CSR_FRAME_HEIGHT, CFG_BITS'(2));
      queue_pixel(16'h8000);
      queue_pixel(16'h7fff);
      drain_block();
      write_csr(CSR_FRAME_WIDTH, CFG_BITS'(4));
      for (k = 0; k < 8; k++)
         queue_pixel(k[0] ? 16'h0000 : 16'hffff);
      drain_block();

      // width over the limit saturates, so no frame end where dropped bits would put one
      write_csr(CSR_FRAME_WIDTH, 13'd4100);
      write_csr(CSR_FRAME_HEIGHT, CFG_BITS'(1));
      for (k = 0; k < 8; k++)
         queue_pixel(random_pixel());
      drain_block();

      // height over the limit saturates the same way
      write_csr(CSR_FRAME_WIDTH, CFG_BITS'(1));
      write_csr(CSR_FRAME_HEIGHT, 13'd4100);
      for (k = 0; k < 8; k++)
         queue_pixel(random_pixel());
      drain_block();

      // random settings, idling off in the tail
      random_sent = 0;
      while (random_sent < 220) begin
         random_phase(random_sent >= 160, phase_sent);
         random_sent += phase_sent;
      end

      drain_block();
      repeat (8) @(negedge clock);
      if (mismatches == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule
